### rtl/anl_pkg.sv
// Shared types and codes for the Annex B to length-prefixed NAL converter.
// No dependencies; compiled first.
`default_nettype none

package anl_pkg;

   localparam int DEF_MAX_NAL_BYTES = 65536;
   localparam int PREFIX_BYTES      = 4;

   localparam int CMD_W  = 2;
   localparam int KIND_W = 2;
   localparam int CLS_W  = 2;
   localparam int LEN_W  = 17;

   localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
   localparam logic [CMD_W-1:0] CMD_EOA  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_POP  = 2'd2;

   localparam logic [KIND_W-1:0] KIND_NOTICE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

   localparam logic [CLS_W-1:0] CLS_SAMPLE = 2'd0;
   localparam logic [CLS_W-1:0] CLS_SPS    = 2'd1;
   localparam logic [CLS_W-1:0] CLS_PPS    = 2'd2;

   localparam logic [4:0] NAL_TYPE_MASK = 5'h1f;
   localparam logic [4:0] NAL_TYPE_SPS  = 5'd7;
   localparam logic [4:0] NAL_TYPE_PPS  = 5'd8;
   localparam logic [4:0] NAL_TYPE_AUD  = 5'd9;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CLS_W-1:0]  nal_class;
      logic [LEN_W-1:0]  nal_length;
      logic [7:0]        out_byte;
      logic              last_byte;
      logic              truncated;
   } res_type;

endpackage

`default_nettype wire

### rtl/anl_req_if.sv
// Request channel: command and stream byte with valid/ready.
// Depends on anl_pkg.
`default_nettype none

interface anl_req_if import anl_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic [7:0]       data_byte;

   modport source (output valid, command, data_byte, input ready);
   modport sink   (input valid, command, data_byte, output ready);
endinterface

`default_nettype wire

### rtl/anl_rsp_if.sv
// Response channel: notices, record bytes and rejections with valid/ready.
// Depends on anl_pkg.
`default_nettype none

interface anl_rsp_if import anl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [CLS_W-1:0]  nal_class;
   logic [LEN_W-1:0]  nal_length;
   logic [7:0]        out_byte;
   logic              last_byte;
   logic              truncated;

   modport source (output valid, kind, nal_class, nal_length, out_byte, last_byte,
                   truncated, input ready);
   modport sink   (input valid, kind, nal_class, nal_length, out_byte, last_byte,
                   truncated, output ready);
endinterface

`default_nettype wire

### rtl/anl_store.sv
// NAL payload buffer: one write port, one read port with registered data.
// Depends on anl_pkg only for the default depth and address width.
`default_nettype none

module anl_store import anl_pkg::*; #(
   parameter int DEPTH  = DEF_MAX_NAL_BYTES,
   parameter int ADDR_W = $clog2(DEF_MAX_NAL_BYTES)
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [7:0]        wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [7:0]        rdata
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

### rtl/annexb_to_length_prefixed_nal_top.sv
// Annex B byte stream to length-prefixed NAL records.
// Push and end-of-unit items finish on acceptance; pops and NAL closes also pass
// a read state for the registered payload RAM data, during which requests stall.
// Results leave through an output register plus one hold stage.
// Synchronous reset clears all control state; the payload RAM is not cleared.
// Depends on anl_pkg, anl_req_if, anl_rsp_if and anl_store.
`default_nettype none

module annexb_to_length_prefixed_nal_top import anl_pkg::*; #(
   parameter int MAX_NAL_BYTES = DEF_MAX_NAL_BYTES
) (
   input wire logic clock,
   input wire logic reset,
   anl_req_if.sink  req_bus,
   anl_rsp_if.source rsp_bus
);

   localparam int CNT_W  = $clog2(MAX_NAL_BYTES + 1);
   localparam int ADDR_W = $clog2(MAX_NAL_BYTES);
   localparam int POS_W  = CNT_W + 1;

   state_type state_ff, state_in;

   logic [CNT_W-1:0] write_count_ff, write_count_in;
   logic [CNT_W-1:0] trimmed_end_ff, trimmed_end_in;
   logic [1:0]       zero_run_ff, zero_run_in;
   logic             inside_nal_ff, inside_nal_in;
   logic             pending_ff, pending_in;
   logic [CLS_W-1:0] pending_class_ff, pending_class_in;
   logic [CNT_W-1:0] pending_length_ff, pending_length_in;
   logic [POS_W-1:0] read_pos_ff, read_pos_in;
   logic             overflow_ff, overflow_in;
   logic             op_pop_ff, op_pop_in;

   logic             rsp_valid_ff;
   res_type          rsp_data_ff;
   res_type          hold_ff;

   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [7:0]        mem_wdata, mem_rdata;

   logic             accept, out_free, needs_read, res_valid;
   res_type          res;
   logic [POS_W-1:0] total, pos_next, rd_idx;
   logic [31:0]      len32;
   logic [7:0]       prefix_byte;
   logic             is_prefix, is_last;
   logic [4:0]       nal_type;

   anl_store #(
      .DEPTH  (MAX_NAL_BYTES),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign accept   = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // record position math
   assign total = POS_W'(pending_length_ff)
                + ((pending_class_ff == CLS_SAMPLE) ? POS_W'(PREFIX_BYTES) : '0);
   assign pos_next  = read_pos_ff + POS_W'(1);
   assign is_prefix = (pending_class_ff == CLS_SAMPLE) && (read_pos_ff < POS_W'(PREFIX_BYTES));
   assign is_last   = (pos_next >= total);
   assign rd_idx    = (pending_class_ff == CLS_SAMPLE) ? read_pos_ff - POS_W'(PREFIX_BYTES)
                                                       : read_pos_ff;
   assign len32     = 32'(pending_length_ff);
   assign nal_type  = mem_rdata[4:0] & NAL_TYPE_MASK;

   always_comb begin
      case (read_pos_ff[1:0])
         2'd0:    prefix_byte = len32[31:24];
         2'd1:    prefix_byte = len32[23:16];
         2'd2:    prefix_byte = len32[15:8];
         default: prefix_byte = len32[7:0];
      endcase
   end

   // datapath and control state
   always_comb begin
      write_count_in    = write_count_ff;
      trimmed_end_in    = trimmed_end_ff;
      zero_run_in       = zero_run_ff;
      inside_nal_in     = inside_nal_ff;
      pending_in        = pending_ff;
      pending_class_in  = pending_class_ff;
      pending_length_in = pending_length_ff;
      read_pos_in       = read_pos_ff;
      overflow_in       = overflow_ff;
      op_pop_in         = op_pop_ff;
      needs_read        = 1'b0;
      res_valid         = 1'b0;
      res               = '0;
      mem_we            = 1'b0;
      mem_waddr         = write_count_ff[ADDR_W-1:0];
      mem_wdata         = req_bus.data_byte;
      mem_re            = 1'b0;
      mem_raddr         = '0;

      if (state_ff == ST_IDLE && accept) begin
         case (req_bus.command)
            CMD_POP: begin
               if (!pending_ff) begin
                  res_valid = 1'b1;
                  res.kind  = KIND_REJECT;
               end else begin
                  needs_read = 1'b1;
                  op_pop_in  = 1'b1;
                  mem_re     = 1'b1;
                  mem_raddr  = rd_idx[ADDR_W-1:0];
               end
            end
            CMD_EOA: begin
               if (pending_ff) begin
                  res_valid = 1'b1;
                  res.kind  = KIND_REJECT;
               end else begin
                  zero_run_in = '0;
                  if (inside_nal_ff) begin
                     inside_nal_in = 1'b0;
                     if (trimmed_end_ff == '0) begin
                        write_count_in = '0;
                        trimmed_end_in = '0;
                        overflow_in    = 1'b0;
                     end else begin
                        needs_read = 1'b1;
                        op_pop_in  = 1'b0;
                        mem_re     = 1'b1;
                     end
                  end
               end
            end
            CMD_PUSH: begin
               if (pending_ff) begin
                  res_valid = 1'b1;
                  res.kind  = KIND_REJECT;
               end else if (req_bus.data_byte == 8'd1 && zero_run_ff == 2'd2) begin
                  zero_run_in   = '0;
                  inside_nal_in = 1'b1;
                  if (inside_nal_ff) begin
                     if (trimmed_end_ff == '0) begin
                        write_count_in = '0;
                        trimmed_end_in = '0;
                        overflow_in    = 1'b0;
                     end else begin
                        needs_read = 1'b1;
                        op_pop_in  = 1'b0;
                        mem_re     = 1'b1;
                     end
                  end
               end else begin
                  if (inside_nal_ff) begin
                     if (write_count_ff < CNT_W'(MAX_NAL_BYTES)) begin
                        mem_we         = 1'b1;
                        write_count_in = write_count_ff + CNT_W'(1);
                        if (req_bus.data_byte != 8'd0) begin
                           trimmed_end_in = write_count_ff + CNT_W'(1);
                        end
                     end else if (req_bus.data_byte != 8'd0) begin
                        overflow_in = 1'b1;
                     end
                  end
                  if (req_bus.data_byte == 8'd0) begin
                     if (zero_run_ff != 2'd2) begin
                        zero_run_in = zero_run_ff + 2'd1;
                     end
                  end else begin
                     zero_run_in = '0;
                  end
               end
            end
            default: begin
               res_valid = 1'b1;
               res.kind  = KIND_REJECT;
            end
         endcase
      end else if (state_ff == ST_READ) begin
         if (op_pop_ff) begin
            res_valid      = 1'b1;
            res.kind       = KIND_BYTE;
            res.nal_class  = pending_class_ff;
            res.nal_length = LEN_W'(pending_length_ff);
            res.out_byte   = is_prefix ? prefix_byte : mem_rdata;
            res.last_byte  = is_last;
            res.truncated  = overflow_ff;
            if (is_last) begin
               pending_in     = 1'b0;
               read_pos_in    = '0;
               write_count_in = '0;
               trimmed_end_in = '0;
               overflow_in    = 1'b0;
            end else begin
               read_pos_in = pos_next;
            end
         end else if (nal_type == NAL_TYPE_AUD) begin
            write_count_in = '0;
            trimmed_end_in = '0;
            overflow_in    = 1'b0;
         end else begin
            pending_class_in  = (nal_type == NAL_TYPE_SPS) ? CLS_SPS :
                                (nal_type == NAL_TYPE_PPS) ? CLS_PPS : CLS_SAMPLE;
            pending_length_in = trimmed_end_ff;
            read_pos_in       = '0;
            pending_in        = 1'b1;
            res_valid         = 1'b1;
            res.kind          = KIND_NOTICE;
            res.nal_class     = pending_class_in;
            res.nal_length    = LEN_W'(trimmed_end_ff);
            res.truncated     = overflow_ff;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (needs_read) begin
                  state_in = ST_READ;
               end else if (res_valid && !out_free) begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_READ: begin
            state_in = (res_valid && !out_free) ? ST_HOLD : ST_IDLE;
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_bus.ready      = (state_ff == ST_IDLE);
      rsp_bus.valid      = rsp_valid_ff;
      rsp_bus.kind       = rsp_data_ff.kind;
      rsp_bus.nal_class  = rsp_data_ff.nal_class;
      rsp_bus.nal_length = rsp_data_ff.nal_length;
      rsp_bus.out_byte   = rsp_data_ff.out_byte;
      rsp_bus.last_byte  = rsp_data_ff.last_byte;
      rsp_bus.truncated  = rsp_data_ff.truncated;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         write_count_ff    <= '0;
         trimmed_end_ff    <= '0;
         zero_run_ff       <= '0;
         inside_nal_ff     <= 1'b0;
         pending_ff        <= 1'b0;
         pending_class_ff  <= CLS_SAMPLE;
         pending_length_ff <= '0;
         read_pos_ff       <= '0;
         overflow_ff       <= 1'b0;
         op_pop_ff         <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         write_count_ff    <= write_count_in;
         trimmed_end_ff    <= trimmed_end_in;
         zero_run_ff       <= zero_run_in;
         inside_nal_ff     <= inside_nal_in;
         pending_ff        <= pending_in;
         pending_class_ff  <= pending_class_in;
         pending_length_ff <= pending_length_in;
         read_pos_ff       <= read_pos_in;
         overflow_ff       <= overflow_in;
         op_pop_ff         <= op_pop_in;
         if (res_valid) begin
            if (out_free) begin
               rsp_valid_ff <= 1'b1;
            end
         end else if (state_ff == ST_HOLD && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         if (out_free) begin
            rsp_data_ff <= res;
         end else begin
            hold_ff <= res;
         end
      end else if (state_ff == ST_HOLD && out_free) begin
         rsp_data_ff <= hold_ff;
      end
   end

`ifndef SYNTH
   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> state_ff != ST_READ)
      else $error("payload read state lasted more than one cycle");

   a_write_only_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_IDLE && !pending_ff))
      else $error("payload write outside idle or while a record is pending");

   a_hold_has_output: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HOLD |-> rsp_valid_ff)
      else $error("hold stage used while output register empty");

   a_pos_in_record: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> (read_pos_ff < total && pending_length_ff != '0))
      else $error("read position outside pending record");
`endif

endmodule

`default_nettype wire

### sim/annexb_to_length_prefixed_nal_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the Annex B to length-prefixed NAL converter: byte pushes,
// access unit ends, pops and unknown commands, predicted and checked by a scoreboard.
// Depends on anl_pkg, anl_req_if, anl_rsp_if and annexb_to_length_prefixed_nal_top.

module annexb_to_length_prefixed_nal_top_tb import anl_pkg::*; ();

   localparam int BUF_BYTES       = 256;
   localparam int RANDOM_ITEMS    = 1000;
   localparam int RSP_HOLD_CYCLES = 150;
   localparam int STALL_LIMIT     = 2000;
   localparam int TAIL_CYCLES     = 16;

   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

   class nal_scoreboard;
      logic [7:0]       nal_bytes [BUF_BYTES];
      int unsigned      fill_count;
      int unsigned      trim_end;
      int unsigned      zero_count;
      int unsigned      read_pos;
      int unsigned      record_len;
      bit               in_nal;
      bit               record_waiting;
      bit               dropped_nonzero;
      logic [CLS_W-1:0] record_class = CLS_SAMPLE;
      res_type          pending_results [$];
      int               errors;
      int               checked;
      int               records;
      int               rejects;
      int               cut_records;

      function void add_expected(res_type r);
         pending_results = {pending_results, r};
      endfunction

      function res_type make_result(logic [KIND_W-1:0] kind, logic [7:0] val, logic last);
         res_type r;
         r.kind       = kind;
         r.nal_class  = (kind == KIND_REJECT) ? CLS_SAMPLE : record_class;
         r.nal_length = (kind == KIND_REJECT) ? '0 : record_len[LEN_W-1:0];
         r.out_byte   = val;
         r.last_byte  = last;
         r.truncated  = (kind == KIND_REJECT) ? 1'b0 : dropped_nonzero;
         return r;
      endfunction

      function void reset_nal();
         fill_count      = 0;
         trim_end        = 0;
         dropped_nonzero = 0;
      endfunction

      function void reject();
         add_expected(make_result(KIND_REJECT, 8'h00, 1'b0));
         rejects++;
      endfunction

      function void close_nal();
         logic [4:0] nal_type;
         if (trim_end == 0) begin
            reset_nal();
            return;
         end
         nal_type = nal_bytes[0][4:0] & NAL_TYPE_MASK;
         if (nal_type == NAL_TYPE_AUD) begin
            reset_nal();
            return;
         end
         record_class = (nal_type == NAL_TYPE_SPS) ? CLS_SPS :
                        (nal_type == NAL_TYPE_PPS) ? CLS_PPS : CLS_SAMPLE;
         record_len     = trim_end;
         read_pos       = 0;
         record_waiting = 1;
         add_expected(make_result(KIND_NOTICE, 8'h00, 1'b0));
         records++;
         if (dropped_nonzero) cut_records++;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [7:0] b);
         int unsigned total;
         int unsigned idx;
         logic [7:0]  val;
         logic        last;
         if (cmd == CMD_POP) begin
            if (!record_waiting) begin
               reject();
               return;
            end
            total = record_len + ((record_class == CLS_SAMPLE) ? PREFIX_BYTES : 0);
            if (record_class == CLS_SAMPLE && read_pos < PREFIX_BYTES) begin
               val = 8'(record_len >> (8 * (3 - read_pos)));
            end else begin
               idx = (record_class == CLS_SAMPLE) ? read_pos - PREFIX_BYTES : read_pos;
               val = (idx < BUF_BYTES) ? nal_bytes[idx] : 8'h00;
            end
            last = (read_pos + 1 >= total);
            add_expected(make_result(KIND_BYTE, val, last));
            if (last) begin
               record_waiting = 0;
               read_pos       = 0;
               reset_nal();
            end else begin
               read_pos++;
            end
            return;
         end
         if ((cmd != CMD_PUSH && cmd != CMD_EOA) || record_waiting) begin
            reject();
            return;
         end
         if (cmd == CMD_EOA) begin
            zero_count = 0;
            if (in_nal) begin
               in_nal = 0;
               close_nal();
            end
            return;
         end
         if (b == 8'h01 && zero_count >= 2) begin
            zero_count = 0;
            if (in_nal) close_nal();
            in_nal = 1;
            return;
         end
         if (in_nal) begin
            if (fill_count < BUF_BYTES) begin
               nal_bytes[fill_count] = b;
               fill_count++;
               if (b != 8'h00) trim_end = fill_count;
            end else if (b != 8'h00) begin
               dropped_nonzero = 1;
            end
         end
         if (b == 8'h00) begin
            if (zero_count < 2) zero_count++;
         end else begin
            zero_count = 0;
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(res_type got);
         res_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: result with none expected: expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         checked++;
         compare_field("kind", want.kind, got.kind);
         compare_field("nal_class", want.nal_class, got.nal_class);
         compare_field("nal_length", want.nal_length, got.nal_length);
         compare_field("out_byte", want.out_byte, got.out_byte);
         compare_field("last_byte", want.last_byte, got.last_byte);
         compare_field("truncated", want.truncated, got.truncated);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   anl_req_if req_bus ();
   anl_rsp_if rsp_bus ();

   nal_scoreboard sb = new();

   int sent_items = 0;
   bit idle_on    = 1'b1;
   bit rsp_hold_req = 1'b0;

   annexb_to_length_prefixed_nal_top #(.MAX_NAL_BYTES(BUF_BYTES)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_result(res_type'({rsp_bus.kind, rsp_bus.nal_class, rsp_bus.nal_length,
                                    rsp_bus.out_byte, rsp_bus.last_byte, rsp_bus.truncated}));
      if (!reset && req_bus.valid && req_bus.ready)
         sb.note_request(req_bus.command, req_bus.data_byte);
   end

   // Sender: called at a falling edge, returns at the falling edge after acceptance.
   task automatic send_item(logic [CMD_W-1:0] cmd, logic [7:0] b);
      int gap;
      if (sent_items % 120 == 0) idle_on = ($urandom_range(0, 3) != 0);
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.command   <= cmd;
      req_bus.data_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic drain_record();
      logic [CMD_W-1:0] noise_cmd;
      while (sb.record_waiting) begin
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
               0: noise_cmd = CMD_PUSH;
               1: noise_cmd = CMD_EOA;
               default: noise_cmd = CMD_UNKNOWN;
            endcase
            send_item(noise_cmd, 8'($urandom_range(0, 255)));
         end else begin
            send_item(CMD_POP, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic push_byte(logic [7:0] b);
      send_item(CMD_PUSH, b);
      drain_record();
   endtask

   task automatic send_nal(logic [4:0] nal_type, int body_len, int zeros_after, bit long_code);
      if (long_code) push_byte(8'h00);
      push_byte(8'h00);
      push_byte(8'h00);
      push_byte(8'h01);
      if (body_len > 0) push_byte({3'($urandom_range(0, 7)), nal_type});
      for (int i = 1; i < body_len; i++)
         push_byte(($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
      repeat (zeros_after) push_byte(8'h00);
   endtask

   function automatic logic [4:0] pick_type();
      case ($urandom_range(0, 5))
         0: return NAL_TYPE_SPS;
         1: return NAL_TYPE_PPS;
         2: return NAL_TYPE_AUD;
         3: return 5'd5;
         4: return 5'd1;
         default: return 5'($urandom_range(0, 31));
      endcase
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 39);
      if (r == 0) return 0;
      if (r == 1) return $urandom_range(BUF_BYTES - 16, BUF_BYTES + 40);
      return $urandom_range(1, 24);
   endfunction

   // Receiver with per-item stalls and one long hold-off on request.
   initial begin
      int gap;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            rsp_hold_req = 1'b0;
         end
         gap = idle_on ? $urandom_range(0, 3) : 0;
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   initial begin
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [7:0] lead_bytes [16];
      int         nal_count;
      req_bus.valid     = 1'b0;
      req_bus.command   = CMD_PUSH;
      req_bus.data_byte = 8'h00;
      lead_bytes = '{8'hFF, 8'h00, 8'h00, 8'h01, 8'h09, 8'hF0, 8'h00, 8'h00,
                     8'h00, 8'h01, 8'h67, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // rejects, junk before first code, AUD dropped by a 4-byte code, SPS closed by a code
      send_item(CMD_POP, 8'h00);
      send_item(CMD_UNKNOWN, 8'hFF);
      send_item(CMD_EOA, 8'h00);
      foreach (lead_bytes[i]) send_item(CMD_PUSH, lead_bytes[i]);
      send_item(CMD_PUSH, 8'h55);
      send_item(CMD_EOA, 8'h00);
      send_item(CMD_POP, 8'h00);
      send_item(CMD_POP, 8'h00);
      send_item(CMD_EOA, 8'h00);
      send_item(CMD_POP, 8'h00);

      // long sample NAL drained while the receiver holds off
      send_nal(5'd5, 60, 0, 1'b0);
      rsp_hold_req = 1'b1;
      send_item(CMD_EOA, 8'h00);
      drain_record();

      while (sent_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 6))
               send_item(CMD_W'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            drain_record();
         end else begin
            repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
            nal_count = $urandom_range(1, 4);
            for (int k = 0; k < nal_count; k++)
               send_nal(pick_type(), pick_length(), $urandom_range(0, 3),
                        $urandom_range(0, 1));
            if ($urandom_range(0, 3) != 0) begin
               send_item(CMD_EOA, 8'h00);
               drain_record();
            end
         end
      end
      req_bus.valid <= 1'b0;

      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d items; checked %0d results with %0d mismatches.",
               sent_items, sb.checked, sb.errors);
      $display("Covered %0d records (%0d truncated) and %0d rejected commands.",
               sb.records, sb.cut_records, sb.rejects);
      if (sb.errors == 0 && sb.pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### annexb_to_length_prefixed_nal_top.f
rtl/anl_pkg.sv
rtl/anl_req_if.sv
rtl/anl_rsp_if.sv
rtl/anl_store.sv
rtl/annexb_to_length_prefixed_nal_top.sv
sim/annexb_to_length_prefixed_nal_top_tb.sv
